FILE: sv/salcp_pkg.sv
// ----------------------------------------------------------------------------
// salcp_pkg
// Shared types and codes for the suffix array / LCP builder.
// ----------------------------------------------------------------------------
`default_nettype none

package salcp_pkg;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_UNBUILT = 2'd2;
  localparam logic [1:0] ST_TRUNC   = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_CLR,
    S_CNT0,
    S_PS,
    S_SC0,
    S_CNT1,
    S_SC1,
    S_RANK,
    S_COPY,
    S_LD,
    S_LA,
    S_LB,
    S_LC
  } state_t;

  typedef struct packed {
    logic built;
    logic overflow;
  } flags_t;

endpackage

`default_nettype wire

FILE: sv/salcp_resp.sv
// ----------------------------------------------------------------------------
// salcp_resp
// Read response stage: registers the status of a read item and forms the
// result fields from the registered memory data.
// ----------------------------------------------------------------------------
`default_nettype none

module salcp_resp #(
  parameter int LW = 11,
  parameter int PW = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  rd_acc,
  input  wire logic [9:0]            rank,
  input  wire logic [LW-1:0]         len,
  input  wire salcp_pkg::flags_t     flags,
  input  wire logic [PW-1:0]         sa_rd,
  input  wire logic [PW-1:0]         lcp_rd,
  output logic                       done,
  output logic [9:0]                 suffix_start,
  output logic [9:0]                 lcp_with_next,
  output logic [1:0]                 status
);

  logic       vld;
  logic [1:0] st;
  logic       data_ok;
  logic [31:0] sa_w;
  logic [31:0] lcp_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= rd_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_acc) begin
      if (!flags.built) begin
        st <= salcp_pkg::ST_UNBUILT;
      end else if (32'(rank) >= 32'(len)) begin
        st <= salcp_pkg::ST_RANGE;
      end else if (flags.overflow) begin
        st <= salcp_pkg::ST_TRUNC;
      end else begin
        st <= salcp_pkg::ST_OK;
      end
    end
  end

  assign sa_w    = 32'(sa_rd);
  assign lcp_w   = 32'(lcp_rd);
  assign data_ok = (st == salcp_pkg::ST_OK) || (st == salcp_pkg::ST_TRUNC);

  assign done          = vld;
  assign status        = st;
  assign suffix_start  = data_ok ? sa_w[9:0] : 10'd0;
  assign lcp_with_next = data_ok ? lcp_w[9:0] : 10'd0;

endmodule

`default_nettype wire

FILE: sv/suffix_array_lcp_builder.sv
// ----------------------------------------------------------------------------
// suffix_array_lcp_builder
// Builds the suffix array and LCP array of a loaded text in on-chip memory.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. operation 0 appends
//   text_byte; is_last on an append ends the text and starts the build.
//   operation 1 reads rank rank_index; its result appears in the next cycle with
//   done high for one cycle (suffix_start, lcp_with_next, status).
//   Appends and reads go at one item per cycle while busy is low. An append
//   after a finished build starts a new text. Bytes beyond MAX_LEN are
//   dropped and reads then report a truncated text.
//   Build: the ranks are seeded from the text, then the build runs prefix
//   doubling with two counting sorts per round through memories with one
//   read and one write port each, NB = max(MAX_LEN,ALPHABET)+2 buckets,
//   and ends with a Kasai LCP pass.
//   Rounds is at most log2(n)+1. busy stays high for the whole build.
//   Reset clears length and flags; no memory clearing pass is needed.
//   Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module suffix_array_lcp_builder #(
  parameter int MAX_LEN  = 1024,
  parameter int ALPHABET = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       operation,
  input  wire logic [7:0] text_byte,
  input  wire logic       is_last,
  input  wire logic [9:0] rank_index,
  output logic            done,
  output logic [9:0]      suffix_start,
  output logic [9:0]      lcp_with_next,
  output logic [1:0]      status
);

  localparam int NB = ((MAX_LEN > ALPHABET) ? MAX_LEN : ALPHABET) + 2;
  localparam int PW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int KW = $clog2(NB);
  localparam int CW = KW + 1;
  localparam int XW = LW + 2;

  // memories
  logic [7:0]    t_mem   [MAX_LEN];
  logic [KW-1:0] r_mem   [MAX_LEN];
  logic [KW-1:0] rt_mem  [MAX_LEN];
  logic [PW-1:0] sa_mem  [MAX_LEN];
  logic [PW-1:0] o_mem   [MAX_LEN];
  logic [PW-1:0] lcp_mem [MAX_LEN];
  logic [LW-1:0] b_mem   [NB];

  logic          t_we, r_we, rt_we, sa_we, o_we, lcp_we, b_we;
  logic [PW-1:0] t_wa, r_wa, rt_wa, sa_wa, o_wa, lcp_wa;
  logic [PW-1:0] t_ra, r_ra, rt_ra, sa_ra, o_ra, lcp_ra;
  logic [KW-1:0] b_wa, b_ra;
  logic [7:0]    t_wd, t_rd;
  logic [KW-1:0] r_wd, r_rd, rt_wd, rt_rd;
  logic [PW-1:0] sa_wd, sa_rd, o_wd, o_rd, lcp_wd, lcp_rd;
  logic [LW-1:0] b_wd, b_rd;

  // control registers
  salcp_pkg::state_t state, state_next;
  logic [1:0]    ph;
  logic [1:0]    ph_max;
  logic [LW-1:0] len;
  logic          built;
  logic          ovf;
  logic          pass;
  logic [XW-1:0] k;
  logic [CW-1:0] i_cnt;
  logic [PW-1:0] rnk;
  logic [KW-1:0] key;
  logic [PW-1:0] cur;
  logic [LW-1:0] sum;
  logic [KW-1:0] prev_r, prev_s, cur_r;
  logic [LW-1:0] h;
  logic [7:0]    tch;
  logic [PW-1:0] lr;

  // decoded conditions
  logic          acc, app, rd_acc, room;
  logic [LW-1:0] len_b, len_after;
  logic [7:0]    tb;
  logic [PW-1:0] idx;
  logic [KW-1:0] bidx;
  logic          elem_last, bkt_last, step_end;
  logic [XW-1:0] ipk, bpk, ih, jh;
  logic          sk_ok, bk_ok, lcp_run, rank_last, r_done, diff;
  logic [KW-1:0] key0, sb;
  logic [PW-1:0] newr;
  salcp_pkg::flags_t flags;

  assign busy   = (state != salcp_pkg::S_IDLE);
  assign acc    = start && !busy;
  assign app    = acc && (operation == salcp_pkg::OP_APPEND);
  assign rd_acc = acc && (operation == salcp_pkg::OP_READ);

  assign len_b     = built ? '0 : len;
  assign room      = len_b < LW'(MAX_LEN);
  assign len_after = room ? len_b + LW'(1) : len_b;
  assign tb        = (9'(text_byte) >= 9'(ALPHABET)) ? 8'(ALPHABET - 1) : text_byte;

  assign idx       = i_cnt[PW-1:0];
  assign bidx      = i_cnt[KW-1:0];
  assign elem_last = (i_cnt == CW'(len) - CW'(1));
  assign bkt_last  = (i_cnt == CW'(NB - 1));
  assign ipk       = XW'(i_cnt) + k;
  assign sk_ok     = ipk < XW'(len);
  assign bpk       = XW'(cur) + k;
  assign bk_ok     = bpk < XW'(len);
  assign key0      = sk_ok ? r_rd + KW'(1) : '0;
  assign sb        = bk_ok ? r_rd + KW'(1) : '0;
  assign ih        = XW'(i_cnt) + XW'(h);
  assign jh        = XW'(cur) + XW'(h);
  assign lcp_run   = (ih < XW'(len)) && (jh < XW'(len));
  assign rank_last = (r_rd == KW'(len) - KW'(1));
  assign r_done    = (XW'(rnk) == XW'(len) - XW'(1)) || (k >= XW'(len));
  assign diff      = (cur_r != prev_r) || (sb != prev_s);
  assign newr      = (i_cnt == '0) ? '0 : rnk + PW'(diff);

  always_comb begin
    unique case (state)
      salcp_pkg::S_INIT, salcp_pkg::S_PS, salcp_pkg::S_COPY: ph_max = 2'd1;
      salcp_pkg::S_CNT0, salcp_pkg::S_SC0, salcp_pkg::S_CNT1,
      salcp_pkg::S_LD:                                      ph_max = 2'd2;
      salcp_pkg::S_SC1, salcp_pkg::S_RANK:                  ph_max = 2'd3;
      default:                                              ph_max = 2'd0;
    endcase
  end
  assign step_end = (ph == ph_max);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      salcp_pkg::S_IDLE:
        if (app && is_last) state_next = salcp_pkg::S_INIT;
      salcp_pkg::S_INIT:
        if (step_end && elem_last) state_next = salcp_pkg::S_CLR;
      salcp_pkg::S_CLR:
        if (bkt_last) state_next = pass ? salcp_pkg::S_CNT1 : salcp_pkg::S_CNT0;
      salcp_pkg::S_CNT0, salcp_pkg::S_CNT1:
        if (step_end && elem_last) state_next = salcp_pkg::S_PS;
      salcp_pkg::S_PS:
        if (step_end && bkt_last) state_next = pass ? salcp_pkg::S_SC1 : salcp_pkg::S_SC0;
      salcp_pkg::S_SC0:
        if (step_end && elem_last) state_next = salcp_pkg::S_CLR;
      salcp_pkg::S_SC1:
        if (step_end && elem_last) state_next = salcp_pkg::S_RANK;
      salcp_pkg::S_RANK:
        if (step_end && elem_last) state_next = salcp_pkg::S_COPY;
      salcp_pkg::S_COPY:
        if (step_end && elem_last) state_next = r_done ? salcp_pkg::S_LD : salcp_pkg::S_CLR;
      salcp_pkg::S_LD:
        if (ph == 2'd1 && rank_last && elem_last) state_next = salcp_pkg::S_IDLE;
        else if (ph == 2'd2) state_next = salcp_pkg::S_LA;
      salcp_pkg::S_LA:
        if (lcp_run) state_next = salcp_pkg::S_LB;
        else state_next = elem_last ? salcp_pkg::S_IDLE : salcp_pkg::S_LD;
      salcp_pkg::S_LB:
        state_next = salcp_pkg::S_LC;
      salcp_pkg::S_LC:
        if (t_rd == tch) state_next = salcp_pkg::S_LA;
        else state_next = elem_last ? salcp_pkg::S_IDLE : salcp_pkg::S_LD;
      default:
        state_next = salcp_pkg::S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    t_we = 1'b0;  t_wa = '0;  t_wd = '0;  t_ra = '0;
    r_we = 1'b0;  r_wa = '0;  r_wd = '0;  r_ra = '0;
    rt_we = 1'b0; rt_wa = '0; rt_wd = '0; rt_ra = '0;
    sa_we = 1'b0; sa_wa = '0; sa_wd = '0; sa_ra = '0;
    o_we = 1'b0;  o_wa = '0;  o_wd = '0;  o_ra = '0;
    lcp_we = 1'b0; lcp_wa = '0; lcp_wd = '0; lcp_ra = '0;
    b_we = 1'b0;  b_wa = '0;  b_wd = '0;  b_ra = '0;
    unique case (state)
      salcp_pkg::S_IDLE: begin
        sa_ra  = PW'(rank_index);
        lcp_ra = PW'(rank_index);
        if (app && room) begin
          t_we = 1'b1;
          t_wa = len_b[PW-1:0];
          t_wd = tb;
        end
      end
      salcp_pkg::S_INIT: begin
        t_ra = idx;
        if (ph == 2'd1) begin
          r_we = 1'b1; r_wa = idx; r_wd = KW'(t_rd);
        end
      end
      salcp_pkg::S_CLR: begin
        b_we = 1'b1; b_wa = bidx; b_wd = '0;
      end
      salcp_pkg::S_CNT0, salcp_pkg::S_SC0: begin
        r_ra = ipk[PW-1:0];
        b_ra = key0;
        if (ph == 2'd2) begin
          b_we = 1'b1; b_wa = key; b_wd = b_rd + LW'(1);
          if (state == salcp_pkg::S_SC0) begin
            o_we = 1'b1; o_wa = b_rd[PW-1:0]; o_wd = idx;
          end
        end
      end
      salcp_pkg::S_CNT1: begin
        r_ra = idx;
        b_ra = r_rd;
        if (ph == 2'd2) begin
          b_we = 1'b1; b_wa = key; b_wd = b_rd + LW'(1);
        end
      end
      salcp_pkg::S_PS: begin
        b_ra = bidx;
        if (ph == 2'd1) begin
          b_we = 1'b1; b_wa = bidx; b_wd = sum;
        end
      end
      salcp_pkg::S_SC1: begin
        o_ra = idx;
        r_ra = o_rd;
        b_ra = r_rd;
        if (ph == 2'd3) begin
          sa_we = 1'b1; sa_wa = b_rd[PW-1:0]; sa_wd = cur;
          b_we = 1'b1; b_wa = key; b_wd = b_rd + LW'(1);
        end
      end
      salcp_pkg::S_RANK: begin
        sa_ra = idx;
        r_ra  = (ph == 2'd1) ? sa_rd : bpk[PW-1:0];
        if (ph == 2'd3) begin
          rt_we = 1'b1; rt_wa = cur; rt_wd = KW'(newr);
        end
      end
      salcp_pkg::S_COPY: begin
        rt_ra = idx;
        if (ph == 2'd1) begin
          r_we = 1'b1; r_wa = idx; r_wd = rt_rd;
        end
      end
      salcp_pkg::S_LD: begin
        r_ra  = idx;
        sa_ra = r_rd[PW-1:0] + PW'(1);
        if (ph == 2'd1 && rank_last) begin
          lcp_we = 1'b1; lcp_wa = r_rd[PW-1:0]; lcp_wd = '0;
        end
      end
      salcp_pkg::S_LA: begin
        t_ra = ih[PW-1:0];
        if (!lcp_run) begin
          lcp_we = 1'b1; lcp_wa = lr; lcp_wd = PW'(h);
        end
      end
      salcp_pkg::S_LB: begin
        t_ra = jh[PW-1:0];
      end
      salcp_pkg::S_LC: begin
        if (t_rd != tch) begin
          lcp_we = 1'b1; lcp_wa = lr; lcp_wd = PW'(h);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (t_we) t_mem[t_wa] <= t_wd;
    t_rd <= t_mem[t_ra];
  end
  always_ff @(posedge clk) begin
    if (r_we) r_mem[r_wa] <= r_wd;
    r_rd <= r_mem[r_ra];
  end
  always_ff @(posedge clk) begin
    if (rt_we) rt_mem[rt_wa] <= rt_wd;
    rt_rd <= rt_mem[rt_ra];
  end
  always_ff @(posedge clk) begin
    if (sa_we) sa_mem[sa_wa] <= sa_wd;
    sa_rd <= sa_mem[sa_ra];
  end
  always_ff @(posedge clk) begin
    if (o_we) o_mem[o_wa] <= o_wd;
    o_rd <= o_mem[o_ra];
  end
  always_ff @(posedge clk) begin
    if (lcp_we) lcp_mem[lcp_wa] <= lcp_wd;
    lcp_rd <= lcp_mem[lcp_ra];
  end
  always_ff @(posedge clk) begin
    if (b_we) b_mem[b_wa] <= b_wd;
    b_rd <= b_mem[b_ra];
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= salcp_pkg::S_IDLE;
      ph    <= '0;
      len   <= '0;
      built <= 1'b0;
      ovf   <= 1'b0;
      pass  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        salcp_pkg::S_IDLE: begin
          ph    <= '0;
          i_cnt <= '0;
          if (app) begin
            built <= 1'b0;
            len   <= len_after;
            ovf   <= room ? (ovf && !built) : 1'b1;
            k     <= XW'(1);
            pass  <= 1'b0;
          end
        end
        salcp_pkg::S_CLR: begin
          i_cnt <= bkt_last ? '0 : i_cnt + CW'(1);
          sum   <= '0;
        end
        salcp_pkg::S_PS: begin
          if (ph == 2'd1) sum <= sum + b_rd;
          if (step_end) begin
            ph    <= '0;
            i_cnt <= bkt_last ? '0 : i_cnt + CW'(1);
          end else begin
            ph <= ph + 2'd1;
          end
        end
        salcp_pkg::S_LD: begin
          if (ph == 2'd1) begin
            lr <= r_rd[PW-1:0];
            if (rank_last) begin
              h     <= '0;
              ph    <= '0;
              i_cnt <= elem_last ? '0 : i_cnt + CW'(1);
              if (elem_last) built <= 1'b1;
            end else begin
              ph <= 2'd2;
            end
          end else if (ph == 2'd2) begin
            cur <= sa_rd;
            ph  <= '0;
          end else begin
            ph <= 2'd1;
          end
        end
        salcp_pkg::S_LA, salcp_pkg::S_LC: begin
          if (state == salcp_pkg::S_LC && t_rd == tch) begin
            h <= h + LW'(1);
          end else if (state == salcp_pkg::S_LC || !lcp_run) begin
            if (h != '0) h <= h - LW'(1);
            i_cnt <= elem_last ? '0 : i_cnt + CW'(1);
            if (elem_last) built <= 1'b1;
          end
        end
        salcp_pkg::S_LB: begin
          tch <= t_rd;
        end
        default: begin
          // element passes: one item of the text per step
          case (state)
            salcp_pkg::S_CNT0, salcp_pkg::S_SC0:
              if (ph == 2'd1) key <= key0;
            salcp_pkg::S_CNT1:
              if (ph == 2'd1) key <= r_rd;
            salcp_pkg::S_SC1: begin
              if (ph == 2'd1) cur <= o_rd;
              if (ph == 2'd2) key <= r_rd;
            end
            salcp_pkg::S_RANK: begin
              if (ph == 2'd1) cur <= sa_rd;
              if (ph == 2'd2) cur_r <= r_rd;
              if (ph == 2'd3) begin
                rnk    <= newr;
                prev_r <= cur_r;
                prev_s <= sb;
              end
            end
            default: begin
            end
          endcase
          if (step_end) begin
            ph    <= '0;
            i_cnt <= elem_last ? '0 : i_cnt + CW'(1);
            if (elem_last) begin
              if (state == salcp_pkg::S_SC0) pass <= 1'b1;
              if (state == salcp_pkg::S_COPY) begin
                pass <= 1'b0;
                k    <= k << 1;
                h    <= '0;
              end
            end
          end else begin
            ph <= ph + 2'd1;
          end
        end
      endcase
    end
  end

  assign flags.built    = built;
  assign flags.overflow = ovf;

  salcp_resp #(
    .LW (LW),
    .PW (PW)
  ) u_resp (
    .clk           (clk),
    .rst           (rst),
    .rd_acc        (rd_acc),
    .rank          (rank_index),
    .len           (len),
    .flags         (flags),
    .sa_rd         (sa_rd),
    .lcp_rd        (lcp_rd),
    .done          (done),
    .suffix_start  (suffix_start),
    .lcp_with_next (lcp_with_next),
    .status        (status)
  );

  a_done_follows_read: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && operation == salcp_pkg::OP_READ))
    else $error("result without a read item");

  a_build_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state != salcp_pkg::S_IDLE) |-> (len != '0))
    else $error("build running on an empty text");

  a_built_after_lcp: assert property (@(posedge clk) disable iff (rst)
    $rose(built) |-> ($past(state) == salcp_pkg::S_LD || $past(state) == salcp_pkg::S_LA ||
                      $past(state) == salcp_pkg::S_LC))
    else $error("built flag set outside the LCP pass");

  a_idle_after_built: assert property (@(posedge clk) disable iff (rst)
    $rose(built) |-> (state == salcp_pkg::S_IDLE))
    else $error("built flag set while still busy");

endmodule

`default_nettype wire

FILE: dv/suffix_array_lcp_builder_tb.sv
// ----------------------------------------------------------------------------
// suffix_array_lcp_builder_tb
// Loads texts byte by byte, lets the block sort its suffixes, then reads
// ranks back and checks start position, LCP and status against a local
// suffix sorter. Directed table first, then random texts and reads with
// bursty stimulus, including one text that runs past capacity.
// ----------------------------------------------------------------------------
module suffix_array_lcp_builder_tb;

  localparam int TEXT_CAP    = 1024;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic [9:0] start_pos;
    logic [9:0] lcp;
    logic [1:0] code;
  } rank_result_t;

  typedef struct {
    logic         op;
    logic [7:0]   text_char;
    logic         last;
    logic [9:0]   rank;
    bit           typed;
    rank_result_t want;
  } table_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       operation = salcp_pkg::OP_APPEND;
  logic [7:0] text_byte = 8'd0;
  logic       is_last = 1'b0;
  logic [9:0] rank_index = 10'd0;
  logic       busy, done;
  logic [9:0] suffix_start, lcp_with_next;
  logic [1:0] status;

  suffix_array_lcp_builder dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .text_byte(text_byte), .is_last(is_last),
    .rank_index(rank_index), .done(done), .suffix_start(suffix_start),
    .lcp_with_next(lcp_with_next), .status(status)
  );

  always #5 clk = ~clk;

  // local copy of the text and the sorted arrays
  logic [7:0] text_mem[TEXT_CAP];
  int         text_len;
  bit         arrays_built, text_truncated;
  int         suffix_order[TEXT_CAP];
  int         merge_buf[TEXT_CAP];
  int         lcp_mem[TEXT_CAP];

  rank_result_t pending_reads[$];
  int errors = 0;
  int burst_left = 0;
  int cycles = 0;
  int items_sent = 0;

  function automatic bit suffix_less(int a, int b);
    int h;
    h = 0;
    while (a + h < text_len && b + h < text_len && text_mem[a+h] == text_mem[b+h])
      h++;
    if (a + h >= text_len) return 1'b1;   // proper prefix sorts first
    if (b + h >= text_len) return 1'b0;
    return text_mem[a+h] < text_mem[b+h];
  endfunction

  function automatic int common_prefix(int a, int b);
    int h;
    h = 0;
    while (a + h < text_len && b + h < text_len && text_mem[a+h] == text_mem[b+h])
      h++;
    return h;
  endfunction

  task automatic sort_suffixes();
    int w, lo, mid, hi, i, j, k;
    for (i = 0; i < text_len; i++) suffix_order[i] = i;
    for (w = 1; w < text_len; w *= 2) begin
      for (lo = 0; lo < text_len; lo += 2 * w) begin
        mid = (lo + w < text_len) ? lo + w : text_len;
        hi  = (lo + 2 * w < text_len) ? lo + 2 * w : text_len;
        i = lo; j = mid; k = lo;
        while (i < mid || j < hi) begin
          if (j >= hi || (i < mid && !suffix_less(suffix_order[j], suffix_order[i])))
            merge_buf[k++] = suffix_order[i++];
          else
            merge_buf[k++] = suffix_order[j++];
        end
      end
      for (i = 0; i < text_len; i++) suffix_order[i] = merge_buf[i];
    end
    for (i = 0; i < text_len; i++)
      lcp_mem[i] = (i == text_len - 1) ? 0
                   : common_prefix(suffix_order[i], suffix_order[i+1]);
    arrays_built = 1'b1;
  endtask

  // updates the local state for one accepted item; returns 1 if a read
  task automatic predict_item(input logic op, input logic [7:0] b, input logic l,
                              input logic [9:0] r, output bit is_read,
                              output rank_result_t res);
    res = '{10'd0, 10'd0, salcp_pkg::ST_OK};
    is_read = (op == salcp_pkg::OP_READ);
    if (op == salcp_pkg::OP_APPEND) begin
      if (arrays_built) begin
        text_len = 0;
        arrays_built = 1'b0;
        text_truncated = 1'b0;
      end
      if (text_len < TEXT_CAP) text_mem[text_len++] = b;
      else text_truncated = 1'b1;
      if (l) sort_suffixes();
    end else if (!arrays_built) begin
      res.code = salcp_pkg::ST_UNBUILT;
    end else if (r >= text_len) begin
      res.code = salcp_pkg::ST_RANGE;
    end else begin
      res.start_pos = suffix_order[r][9:0];
      res.lcp       = lcp_mem[r][9:0];
      res.code      = text_truncated ? salcp_pkg::ST_TRUNC : salcp_pkg::ST_OK;
    end
  endtask

  task automatic send_item(input logic op, input logic [7:0] b, input logic l,
                           input logic [9:0] r, input bit typed,
                           input rank_result_t want);
    int gap;
    bit is_read;
    rank_result_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
        @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    @(negedge clk);
    start      <= 1'b1;
    operation  <= op;
    text_byte  <= b;
    is_last    <= l;
    rank_index <= r;
    do @(posedge clk); while (busy);
    predict_item(op, b, l, r, is_read, res);
    if (typed) res = want;
    if (is_read) pending_reads.insert(pending_reads.size(), res);
    burst_left--;
    items_sent++;
  endtask

  task automatic append_char(input logic [7:0] b, input logic l);
    send_item(salcp_pkg::OP_APPEND, b, l, 10'd0, 1'b0, '{10'd0, 10'd0, salcp_pkg::ST_OK});
  endtask

  task automatic read_rank(input logic [9:0] r);
    send_item(salcp_pkg::OP_READ, 8'($urandom), 1'($urandom), r, 1'b0,
              '{10'd0, 10'd0, salcp_pkg::ST_OK});
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_reads.size() == 0) begin
        $display("%0t: result with none expected: start %0d lcp %0d status %0d",
                 $time, suffix_start, lcp_with_next, status);
        errors++;
      end else begin
        rank_result_t exp_r;
        exp_r = pending_reads.pop_front();
        if (suffix_start !== exp_r.start_pos) begin
          $display("%0t: suffix_start expected %0d got %0d",
                   $time, exp_r.start_pos, suffix_start);
          errors++;
        end
        if (lcp_with_next !== exp_r.lcp) begin
          $display("%0t: lcp_with_next expected %0d got %0d",
                   $time, exp_r.lcp, lcp_with_next);
          errors++;
        end
        if (status !== exp_r.code) begin
          $display("%0t: status expected %0d got %0d", $time, exp_r.code, status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  table_row_t directed[] = '{
    // reads right after reset: nothing built
    '{salcp_pkg::OP_READ,   8'h00, 1'b0, 10'd0,    1'b1, '{10'd0, 10'd0, salcp_pkg::ST_UNBUILT}},
    '{salcp_pkg::OP_READ,   8'hFF, 1'b1, 10'd1023, 1'b1, '{10'd0, 10'd0, salcp_pkg::ST_UNBUILT}},
    // partial text is still unbuilt
    '{salcp_pkg::OP_APPEND, 8'hFF, 1'b0, 10'd0,    1'b0, '{10'd0, 10'd0, salcp_pkg::ST_OK}},
    '{salcp_pkg::OP_READ,   8'h00, 1'b0, 10'd0,    1'b1, '{10'd0, 10'd0, salcp_pkg::ST_UNBUILT}},
    '{salcp_pkg::OP_APPEND, 8'h01, 1'b0, 10'd1023, 1'b0, '{10'd0, 10'd0, salcp_pkg::ST_OK}},
    '{salcp_pkg::OP_APPEND, 8'hFF, 1'b0, 10'd0,    1'b0, '{10'd0, 10'd0, salcp_pkg::ST_OK}},
    '{salcp_pkg::OP_APPEND, 8'h01, 1'b1, 10'd0,    1'b0, '{10'd0, 10'd0, salcp_pkg::ST_OK}},
    '{salcp_pkg::OP_READ,   8'h00, 1'b0, 10'd0,    1'b0, '{10'd0, 10'd0, salcp_pkg::ST_OK}},
    '{salcp_pkg::OP_READ,   8'h00, 1'b1, 10'd1,    1'b0, '{10'd0, 10'd0, salcp_pkg::ST_OK}},
    '{salcp_pkg::OP_READ,   8'h00, 1'b0, 10'd2,    1'b0, '{10'd0, 10'd0, salcp_pkg::ST_OK}},
    '{salcp_pkg::OP_READ,   8'h00, 1'b0, 10'd3,    1'b0, '{10'd0, 10'd0, salcp_pkg::ST_OK}},
    '{salcp_pkg::OP_READ,   8'h00, 1'b0, 10'd4,    1'b1, '{10'd0, 10'd0, salcp_pkg::ST_RANGE}},
    '{salcp_pkg::OP_READ,   8'hFF, 1'b0, 10'd1023, 1'b1, '{10'd0, 10'd0, salcp_pkg::ST_RANGE}},
    // new text over the built one, with a zero byte and a single repeat
    '{salcp_pkg::OP_APPEND, 8'h00, 1'b0, 10'd0,    1'b0, '{10'd0, 10'd0, salcp_pkg::ST_OK}},
    '{salcp_pkg::OP_READ,   8'h00, 1'b0, 10'd0,    1'b1, '{10'd0, 10'd0, salcp_pkg::ST_UNBUILT}},
    '{salcp_pkg::OP_APPEND, 8'h80, 1'b0, 10'd0,    1'b0, '{10'd0, 10'd0, salcp_pkg::ST_OK}},
    '{salcp_pkg::OP_APPEND, 8'h00, 1'b1, 10'd0,    1'b0, '{10'd0, 10'd0, salcp_pkg::ST_OK}},
    '{salcp_pkg::OP_READ,   8'h00, 1'b0, 10'd0,    1'b0, '{10'd0, 10'd0, salcp_pkg::ST_OK}},
    '{salcp_pkg::OP_READ,   8'h00, 1'b0, 10'd1,    1'b0, '{10'd0, 10'd0, salcp_pkg::ST_OK}},
    '{salcp_pkg::OP_READ,   8'h00, 1'b0, 10'd2,    1'b0, '{10'd0, 10'd0, salcp_pkg::ST_OK}},
    // one-byte text
    '{salcp_pkg::OP_APPEND, 8'h7F, 1'b1, 10'd0,    1'b0, '{10'd0, 10'd0, salcp_pkg::ST_OK}},
    '{salcp_pkg::OP_READ,   8'h00, 1'b0, 10'd0,    1'b1, '{10'd0, 10'd0, salcp_pkg::ST_OK}},
    '{salcp_pkg::OP_READ,   8'h00, 1'b0, 10'd1,    1'b1, '{10'd0, 10'd0, salcp_pkg::ST_RANGE}}
  };

  initial begin
    int len, n_reads, flavor, i;
    logic [7:0] ch;
    text_len = 0;
    arrays_built = 1'b0;
    text_truncated = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[k])
      send_item(directed[k].op, directed[k].text_char, directed[k].last,
                directed[k].rank, directed[k].typed, directed[k].want);

    // text past capacity: dropped bytes, long common prefixes, truncated status
    for (i = 0; i < TEXT_CAP + 3; i++)
      append_char(($urandom_range(0, 15) == 0) ? 8'h62 : 8'h61, i == TEXT_CAP + 2);
    read_rank(10'd0);
    read_rank(10'd1023);
    for (i = 0; i < 12; i++) read_rank(10'($urandom_range(0, 1023)));

    while (items_sent < 750 + TEXT_CAP) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
      flavor = $urandom_range(0, 2);
      for (i = 0; i < len; i++) begin
        case (flavor)
          0: ch = 8'($urandom_range(1, 255));
          1: ch = 8'h61 + 8'($urandom_range(0, 1));
          default: ch = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(1, 3));
        endcase
        append_char(ch, i == len - 1);
        if (i != len - 1 && $urandom_range(0, 19) == 0)
          read_rank(10'($urandom_range(0, 1023)));
      end
      n_reads = $urandom_range(5, 30);
      for (i = 0; i < n_reads; i++)
        read_rank(($urandom_range(0, 6) == 0) ? 10'($urandom_range(0, 1023))
                                              : 10'($urandom_range(0, len - 1)));
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: filelist.f
sv/salcp_pkg.sv
sv/salcp_resp.sv
sv/suffix_array_lcp_builder.sv
dv/suffix_array_lcp_builder_tb.sv
